/* src/trr_pkg.sv */
`default_nettype none
package trr_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [29:0] NS_PER_S    = 30'd1000000000;
	localparam logic [63:0] PKT_SCALE   = 64'd65536000000000;
	localparam logic [63:0] MBIT_SCALE  = 64'd524288000;
	localparam logic [63:0] USAGE_SCALE = 64'd6553600;

	localparam logic [31:0] INTERVAL_RESET = 32'd1;
	localparam logic [24:0] CAPACITY_RESET = 25'd65536;

	localparam logic [1:0] CFG_INTERVAL  = 2'd0;
	localparam logic [1:0] CFG_CAPACITY  = 2'd1;
	localparam logic [1:0] CFG_START_S   = 2'd2;
	localparam logic [1:0] CFG_START_NS  = 2'd3;

	localparam logic [1:0] CMD_PACKET  = 2'd0;
	localparam logic [1:0] CMD_EXPIRE  = 2'd1;
	localparam logic [1:0] CMD_OBSERVE = 2'd2;

	typedef enum logic [1:0] {
		OP_PACKET,
		OP_EXPIRE,
		OP_OBSERVE,
		OP_BAD
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_INVALID,
		STAT_OVERFLOW,
		STAT_BACKWARDS
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] snap_len;
		logic [15:0] frame_len;
		logic [15:0] expired_flows;
		logic [31:0] now_seconds;
		logic [29:0] now_nanoseconds;
		logic [23:0] active_flows;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic        reported;
		logic [31:0] elapsed_sec;
		logic [29:0] elapsed_nanos;
		logic [63:0] interval_packets;
		logic [63:0] interval_captured_bytes;
		logic [63:0] interval_wire_bytes;
		logic [63:0] interval_expired;
		logic [63:0] packet_rate;
		logic [63:0] captured_mbps;
		logic [63:0] wire_mbps;
		logic [22:0] usage_percent;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] d;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] q;
	} md_rsp_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_MUL,
		MD_CHK,
		MD_DIV,
		MD_DONE
	} md_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_TIME,
		BK_START,
		BK_WAIT,
		BK_DONE
	} bk_state_t;

endpackage
`default_nettype wire

/* src/trr_in_if.sv */
`default_nettype none
interface trr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] snap_len;
	logic [15:0] frame_len;
	logic [15:0] expired_flows;
	logic [31:0] now_seconds;
	logic [29:0] now_nanoseconds;
	logic [23:0] active_flows;

	modport source (output valid, cmd, snap_len, frame_len, expired_flows,
		now_seconds, now_nanoseconds, active_flows, input ready);
	modport sink (input valid, cmd, snap_len, frame_len, expired_flows,
		now_seconds, now_nanoseconds, active_flows, output ready);
endinterface
`default_nettype wire

/* src/trr_out_if.sv */
`default_nettype none
interface trr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        reported;
	logic [31:0] elapsed_sec;
	logic [29:0] elapsed_nanos;
	logic [63:0] interval_packets;
	logic [63:0] interval_captured_bytes;
	logic [63:0] interval_wire_bytes;
	logic [63:0] interval_expired;
	logic [63:0] packet_rate;
	logic [63:0] captured_mbps;
	logic [63:0] wire_mbps;
	logic [22:0] usage_percent;

	modport source (output valid, status, reported, elapsed_sec, elapsed_nanos,
		interval_packets, interval_captured_bytes, interval_wire_bytes, interval_expired,
		packet_rate, captured_mbps, wire_mbps, usage_percent, input ready);
	modport sink (input valid, status, reported, elapsed_sec, elapsed_nanos,
		interval_packets, interval_captured_bytes, interval_wire_bytes, interval_expired,
		packet_rate, captured_mbps, wire_mbps, usage_percent, output ready);
endinterface
`default_nettype wire

/* src/trr_front.sv */
`default_nettype none
module trr_front import trr_pkg::*; (
	trr_in_if.sink   items,
	input  logic     q_full,
	output logic     push,
	output entry_t   entry
);

	assign items.ready = !q_full;
	assign push        = items.valid && !q_full;

	always_comb begin
		entry.snap_len        = items.snap_len;
		entry.frame_len       = items.frame_len;
		entry.expired_flows   = items.expired_flows;
		entry.now_seconds     = items.now_seconds;
		entry.now_nanoseconds = items.now_nanoseconds;
		entry.active_flows    = items.active_flows;
		unique case (items.cmd)
			CMD_PACKET:  entry.op = OP_PACKET;
			CMD_EXPIRE:  entry.op = OP_EXPIRE;
			CMD_OBSERVE: entry.op = OP_OBSERVE;
			default:     entry.op = OP_BAD;
		endcase
	end

endmodule
`default_nettype wire

/* src/trr_queue.sv */
`default_nettype none
module trr_queue import trr_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t rdata
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/trr_muldiv.sv */
`default_nettype none
module trr_muldiv import trr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	md_state_t    st_q, st_d;
	logic [63:0]  a_q, a_d;
	logic [127:0] bsh_q, bsh_d;
	logic [127:0] acc_q, acc_d;
	logic [63:0]  d_q, d_d;
	logic [63:0]  q_q, q_d;
	logic [5:0]   cnt_q, cnt_d;
	logic [64:0]  rem;
	logic [64:0]  rem_sub;
	logic         take;

	assign rsp.done = (st_q == MD_DONE);
	assign rsp.q    = q_q;

	assign rem     = {acc_q[127:63]};
	assign rem_sub = rem - {1'b0, d_q};
	assign take    = (rem >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MD_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q   <= a_d;
		bsh_q <= bsh_d;
		acc_q <= acc_d;
		d_q   <= d_d;
		q_q   <= q_d;
		cnt_q <= cnt_d;
	end

	always_comb begin
		st_d  = st_q;
		a_d   = a_q;
		bsh_d = bsh_q;
		acc_d = acc_q;
		d_d   = d_q;
		q_d   = q_q;
		cnt_d = cnt_q;
		unique case (st_q)
			MD_IDLE: begin
				if (req.start) begin
					a_d   = req.a;
					bsh_d = {64'd0, req.b};
					acc_d = '0;
					d_d   = req.d;
					cnt_d = '0;
					st_d  = MD_MUL;
				end
			end
			MD_MUL: begin
				if (a_q[0]) begin
					acc_d = acc_q + bsh_q;
				end
				a_d   = a_q >> 1;
				bsh_d = bsh_q << 1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					st_d = MD_CHK;
				end
			end
			MD_CHK: begin
				cnt_d = '0;
				if (acc_q[127:64] >= d_q) begin
					q_d  = '1;
					st_d = MD_DONE;
				end else begin
					q_d  = '0;
					st_d = MD_DIV;
				end
			end
			MD_DIV: begin
				acc_d = {(take ? rem_sub[63:0] : rem[63:0]), acc_q[62:0], 1'b0};
				q_d   = {q_q[62:0], take};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					st_d = MD_DONE;
				end
			end
			MD_DONE: begin
				st_d = MD_IDLE;
			end
			default: begin
				st_d = MD_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/trr_back.sv */
`default_nettype none
module trr_back import trr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        q_empty,
	input  entry_t      head,
	output logic        pop,
	output md_req_t     md_req,
	input  md_rsp_t     md_rsp,
	trr_out_if.source   results
);

	logic [31:0] interval_q;
	logic [24:0] cap_q;
	logic [31:0] base_s_q;
	logic [29:0] base_ns_q;
	logic [63:0] tot_q      [4];
	logic [63:0] base_tot_q [4];

	logic [31:0] es_q;
	logic [29:0] ens_q;
	logic [63:0] t_q;
	logic [63:0] d_q [4];
	logic [63:0] qres_q [4];
	logic [23:0] act_q;
	logic [31:0] now_s_q;
	logic [29:0] now_ns_q;
	logic [1:0]  job_q;

	bk_state_t st_q, st_d;
	result_t   out_q, res;
	logic      ov_q;
	logic      out_free;
	logic      out_we, upd_pkt, upd_exp, obs_load, t_load, rate_we, obs_done;

	logic [64:0] pkt_sum, cap_sum, wire_sum, exp_sum;
	logic        pkt_ovf, exp_ovf;
	logic [31:0] es_raw, es_b;
	logic [29:0] ens_b;
	logic        borrow, invalid, backwards, notdue;
	logic [61:0] t_prod;

	assign out_free = !ov_q || results.ready;

	assign pkt_sum  = {1'b0, tot_q[0]} + 65'd1;
	assign cap_sum  = {1'b0, tot_q[1]} + {49'd0, head.snap_len};
	assign wire_sum = {1'b0, tot_q[2]} + {49'd0, head.frame_len};
	assign exp_sum  = {1'b0, tot_q[3]} + {49'd0, head.expired_flows};
	assign pkt_ovf  = pkt_sum[64] || cap_sum[64] || wire_sum[64];
	assign exp_ovf  = exp_sum[64];

	assign invalid = (interval_q == '0) || (cap_q == '0) || (base_ns_q >= NS_PER_S) ||
		(head.now_nanoseconds >= NS_PER_S) || ({1'b0, head.active_flows} > cap_q);
	assign borrow    = head.now_nanoseconds < base_ns_q;
	assign backwards = (head.now_seconds < base_s_q) ||
		((head.now_seconds == base_s_q) && borrow);
	assign es_raw = head.now_seconds - base_s_q;
	assign notdue = (es_raw < interval_q) || ((es_raw == interval_q) && borrow);
	assign es_b   = es_raw - {31'd0, borrow};
	assign ens_b  = borrow ? (head.now_nanoseconds + NS_PER_S - base_ns_q)
		: (head.now_nanoseconds - base_ns_q);

	assign t_prod = 62'(es_q) * 62'(NS_PER_S);

	always_comb begin
		md_req.start = (st_q == BK_START);
		md_req.b     = MBIT_SCALE;
		md_req.d     = t_q;
		case (job_q)
			2'd0: begin
				md_req.a = d_q[0];
				md_req.b = PKT_SCALE;
			end
			2'd1: md_req.a = d_q[1];
			2'd2: md_req.a = d_q[2];
			default: begin
				md_req.a = {40'd0, act_q};
				md_req.b = USAGE_SCALE;
				md_req.d = {39'd0, cap_q};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		pop      = 1'b0;
		out_we   = 1'b0;
		upd_pkt  = 1'b0;
		upd_exp  = 1'b0;
		obs_load = 1'b0;
		t_load   = 1'b0;
		rate_we  = 1'b0;
		obs_done = 1'b0;
		res      = '0;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					pop    = 1'b1;
					out_we = 1'b1;
					unique case (head.op)
						OP_PACKET: begin
							if (pkt_ovf) begin
								res.status = STAT_OVERFLOW;
							end else begin
								upd_pkt = 1'b1;
							end
						end
						OP_EXPIRE: begin
							if (exp_ovf) begin
								res.status = STAT_OVERFLOW;
							end else begin
								upd_exp = 1'b1;
							end
						end
						OP_OBSERVE: begin
							if (invalid) begin
								res.status = STAT_INVALID;
							end else if (backwards) begin
								res.status = STAT_BACKWARDS;
							end else if (!notdue) begin
								out_we   = 1'b0;
								obs_load = 1'b1;
								st_d     = BK_TIME;
							end
						end
						default: res.status = STAT_INVALID;
					endcase
				end
			end
			BK_TIME: begin
				t_load = 1'b1;
				st_d   = BK_START;
			end
			BK_START: begin
				st_d = BK_WAIT;
			end
			BK_WAIT: begin
				if (md_rsp.done) begin
					rate_we = 1'b1;
					st_d    = (job_q == 2'd3) ? BK_DONE : BK_START;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					out_we   = 1'b1;
					obs_done = 1'b1;
					st_d     = BK_IDLE;
					res.status                  = STAT_OK;
					res.reported                = 1'b1;
					res.elapsed_sec             = es_q;
					res.elapsed_nanos           = ens_q;
					res.interval_packets        = d_q[0];
					res.interval_captured_bytes = d_q[1];
					res.interval_wire_bytes     = d_q[2];
					res.interval_expired        = d_q[3];
					res.packet_rate             = qres_q[0];
					res.captured_mbps           = qres_q[1];
					res.wire_mbps               = qres_q[2];
					res.usage_percent           = qres_q[3][22:0];
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			cap_q      <= CAPACITY_RESET;
			base_s_q   <= '0;
			base_ns_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				tot_q[i]      <= '0;
				base_tot_q[i] <= '0;
			end
			job_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INTERVAL: interval_q <= cfg_data;
					CFG_CAPACITY: cap_q      <= cfg_data[24:0];
					CFG_START_S:  base_s_q   <= cfg_data;
					CFG_START_NS: base_ns_q  <= cfg_data[29:0];
					default: ;
				endcase
			end
			if (upd_pkt) begin
				tot_q[0] <= pkt_sum[63:0];
				tot_q[1] <= cap_sum[63:0];
				tot_q[2] <= wire_sum[63:0];
			end
			if (upd_exp) begin
				tot_q[3] <= exp_sum[63:0];
			end
			if (obs_load) begin
				job_q <= '0;
			end else if (rate_we) begin
				job_q <= job_q + 1'b1;
			end
			if (obs_done) begin
				base_s_q  <= now_s_q;
				base_ns_q <= now_ns_q;
				for (int i = 0; i < 4; i++) begin
					base_tot_q[i] <= tot_q[i];
				end
			end
			if (out_we) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (obs_load) begin
			es_q     <= es_b;
			ens_q    <= ens_b;
			act_q    <= head.active_flows;
			now_s_q  <= head.now_seconds;
			now_ns_q <= head.now_nanoseconds;
			for (int i = 0; i < 4; i++) begin
				d_q[i] <= tot_q[i] - base_tot_q[i];
			end
		end
		if (t_load) begin
			t_q <= {2'b00, t_prod} + {34'd0, ens_q};
		end
		if (rate_we) begin
			qres_q[job_q] <= md_rsp.q;
		end
		if (out_we) begin
			out_q <= res;
		end
	end

	assign results.valid                   = ov_q;
	assign results.status                  = out_q.status;
	assign results.reported                = out_q.reported;
	assign results.elapsed_sec             = out_q.elapsed_sec;
	assign results.elapsed_nanos           = out_q.elapsed_nanos;
	assign results.interval_packets        = out_q.interval_packets;
	assign results.interval_captured_bytes = out_q.interval_captured_bytes;
	assign results.interval_wire_bytes     = out_q.interval_wire_bytes;
	assign results.interval_expired        = out_q.interval_expired;
	assign results.packet_rate             = out_q.packet_rate;
	assign results.captured_mbps           = out_q.captured_mbps;
	assign results.wire_mbps               = out_q.wire_mbps;
	assign results.usage_percent           = out_q.usage_percent;

endmodule
`default_nettype wire

/* src/traffic_rate_reporter.sv */
// channel   dir  handshake      payload
// items     in   valid/ready    cmd, lengths, expired flows, time, active flows
// results   out  valid/ready    status, report flag, elapsed time, deltas, rates, usage
// cfg       in   cfg_we         cfg_index, cfg_data
//
// packet, expiry, unknown and non-reporting observe transactions are answered from the idle state.
// an observe that reports holds the back end for four passes through the shared shift-add
// multiply and restoring divide unit, one bit per cycle each; a pass whose quotient
// saturates skips the divide.
// reset clears totals, baseline and queue; registers take their reset values.
// a stalled result register holds the back end; the input queue takes items until full.
`default_nettype none
module traffic_rate_reporter import trr_pkg::*; #(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	trr_in_if.sink      items,
	trr_out_if.source   results
);

	logic    push, q_full, q_empty, pop;
	entry_t  wentry, head;
	md_req_t md_req;
	md_rsp_t md_rsp;

	trr_front u_front (
		.items  (items),
		.q_full (q_full),
		.push   (push),
		.entry  (wentry)
	);

	trr_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rdata  (head)
	);

	trr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	trr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.md_req    (md_req),
		.md_rsp    (md_rsp),
		.results   (results)
	);

endmodule
`default_nettype wire

/* src/trr_checker.sv */
`default_nettype none
module trr_checker import trr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        r_valid,
	input logic        r_ready,
	input logic [1:0]  r_status,
	input logic        r_due,
	input logic [29:0] r_elapsed_nanos,
	input logic [63:0] r_interval_packets,
	input logic [63:0] r_packet_rate,
	input logic [22:0] r_usage
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result dropped while stalled");

	a_due_ok: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_due |-> (r_status == STAT_OK) && (r_elapsed_nanos < NS_PER_S))
		else $error("report with bad status or nanoseconds");

	a_not_due_zero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_due |-> (r_packet_rate == '0) && (r_interval_packets == '0) &&
			(r_elapsed_nanos == '0) && (r_usage == '0))
		else $error("fields not zero without report");

	a_usage_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_usage <= 23'd6553600)
		else $error("usage above full table");

endmodule

bind traffic_rate_reporter trr_checker u_trr_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.r_valid            (results.valid),
	.r_ready            (results.ready),
	.r_status           (results.status),
	.r_due              (results.reported),
	.r_elapsed_nanos    (results.elapsed_nanos),
	.r_interval_packets (results.interval_packets),
	.r_packet_rate      (results.packet_rate),
	.r_usage            (results.usage_percent)
);
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
	import trr_pkg::*;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] snap_len;
		logic [15:0] frame_len;
		logic [15:0] expired_flows;
		logic [31:0] now_seconds;
		logic [29:0] now_nanoseconds;
		logic [23:0] active_flows;
		bit          drain;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	trr_in_if  in_ch();
	trr_out_if out_ch();

	traffic_rate_reporter DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .items(in_ch), .results(out_ch)
	);

	// predictor copy of the block
	logic [31:0] m_interval;
	logic [24:0] m_capacity;
	logic [63:0] m_tot [4];
	logic [63:0] m_base_tot [4];
	logic [31:0] m_base_s;
	logic [29:0] m_base_ns;

	stim_t   pending_q[$];
	result_t expected_q[$];
	stim_t   cur_item;

	int errors = 0;
	int results_seen = 0;
	int reports_seen = 0;
	int items_sent = 0;
	bit idle_mode = 1;
	bit start_hold = 0;
	bit hold_done = 0;
	int hold_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit sent = 0;
	bit got = 0;

	logic [63:0] g_s;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got_v,
			input logic [63:0] exp_v);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got_v, exp_v, $realtime);
	endtask

	function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] d);
		logic [127:0] p;
		logic [127:0] q;
		p = {64'd0, a} * {64'd0, b};
		q = p / {64'd0, d};
		scaled_quot = (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
	endfunction

	task automatic predict_result(input stim_t it, output result_t r);
		logic [63:0] es;
		logic [63:0] ens;
		logic [63:0] t;
		logic [63:0] d [4];
		r = '0;
		r.status = STAT_OK;
		case (op_t'(it.cmd))
			OP_PACKET: begin
				if (m_tot[0] == 64'hFFFF_FFFF_FFFF_FFFF ||
						m_tot[1] > 64'hFFFF_FFFF_FFFF_FFFF - {48'd0, it.snap_len} ||
						m_tot[2] > 64'hFFFF_FFFF_FFFF_FFFF - {48'd0, it.frame_len}) begin
					r.status = STAT_OVERFLOW;
				end else begin
					m_tot[0] = m_tot[0] + 64'd1;
					m_tot[1] = m_tot[1] + {48'd0, it.snap_len};
					m_tot[2] = m_tot[2] + {48'd0, it.frame_len};
				end
			end
			OP_EXPIRE: begin
				if (m_tot[3] > 64'hFFFF_FFFF_FFFF_FFFF - {48'd0, it.expired_flows})
					r.status = STAT_OVERFLOW;
				else
					m_tot[3] = m_tot[3] + {48'd0, it.expired_flows};
			end
			OP_BAD: r.status = STAT_INVALID;
			default: begin
				if (m_interval == 0 || m_capacity == 0 || m_base_ns >= NS_PER_S ||
						it.now_nanoseconds >= NS_PER_S ||
						{1'b0, it.active_flows} > m_capacity) begin
					r.status = STAT_INVALID;
				end else if (it.now_seconds < m_base_s || (it.now_seconds == m_base_s &&
						it.now_nanoseconds < m_base_ns)) begin
					r.status = STAT_BACKWARDS;
				end else begin
					es = {32'd0, it.now_seconds} - {32'd0, m_base_s};
					if (!(es < {32'd0, m_interval} || (es == {32'd0, m_interval} &&
							it.now_nanoseconds < m_base_ns))) begin
						if (it.now_nanoseconds < m_base_ns) begin
							es = es - 64'd1;
							ens = {34'd0, it.now_nanoseconds} + 64'd1000000000 -
								{34'd0, m_base_ns};
						end else begin
							ens = {34'd0, it.now_nanoseconds} - {34'd0, m_base_ns};
						end
						t = es * 64'd1000000000 + ens;
						for (int i = 0; i < 4; i++)
							d[i] = m_tot[i] - m_base_tot[i];
						r.reported = 1;
						r.elapsed_sec = es[31:0];
						r.elapsed_nanos = ens[29:0];
						r.interval_packets = d[0];
						r.interval_captured_bytes = d[1];
						r.interval_wire_bytes = d[2];
						r.interval_expired = d[3];
						r.packet_rate = scaled_quot(d[0], PKT_SCALE, t);
						r.captured_mbps = scaled_quot(d[1], MBIT_SCALE, t);
						r.wire_mbps = scaled_quot(d[2], MBIT_SCALE, t);
						r.usage_percent = 23'(({40'd0, it.active_flows} * USAGE_SCALE) /
							{39'd0, m_capacity});
						m_base_s = it.now_seconds;
						m_base_ns = it.now_nanoseconds;
						for (int i = 0; i < 4; i++)
							m_base_tot[i] = m_tot[i];
					end
				end
			end
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		result_t r;
		sent <= in_ch.valid && in_ch.ready;
		if (in_ch.valid && in_ch.ready) begin
			predict_result(cur_item, r);
			expected_q.push_back(r);
			items_sent++;
		end
	end

	always @(negedge clk) begin
		logic nv;
		stim_t it;
		if (arst_n) begin
			nv = in_ch.valid && !sent;
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_q.size() > 0 &&
						!(pending_q[0].drain && expected_q.size() > 0)) begin
					it = pending_q.pop_front();
					cur_item = it;
					in_ch.cmd <= it.cmd;
					in_ch.snap_len <= it.snap_len;
					in_ch.frame_len <= it.frame_len;
					in_ch.expired_flows <= it.expired_flows;
					in_ch.now_seconds <= it.now_seconds;
					in_ch.now_nanoseconds <= it.now_nanoseconds;
					in_ch.active_flows <= it.active_flows;
					nv = 1;
					gap_left <= idle_mode ? $urandom_range(0, 19) : 0;
				end
			end
			in_ch.valid <= nv;
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t e;
		got <= out_ch.valid && out_ch.ready;
		if (out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected transaction", {62'd0, out_ch.status}, 0);
			end else begin
				e = expected_q.pop_front();
				if (e.reported) reports_seen++;
				if (out_ch.status != e.status)
					report_mismatch("status", out_ch.status, e.status);
				if (out_ch.reported != e.reported)
					report_mismatch("reported", out_ch.reported, e.reported);
				if (out_ch.elapsed_sec != e.elapsed_sec)
					report_mismatch("elapsed_sec", out_ch.elapsed_sec, e.elapsed_sec);
				if (out_ch.elapsed_nanos != e.elapsed_nanos)
					report_mismatch("elapsed_nanos", out_ch.elapsed_nanos, e.elapsed_nanos);
				if (out_ch.interval_packets != e.interval_packets)
					report_mismatch("interval_packets", out_ch.interval_packets,
						e.interval_packets);
				if (out_ch.interval_captured_bytes != e.interval_captured_bytes)
					report_mismatch("interval_captured_bytes", out_ch.interval_captured_bytes,
						e.interval_captured_bytes);
				if (out_ch.interval_wire_bytes != e.interval_wire_bytes)
					report_mismatch("interval_wire_bytes", out_ch.interval_wire_bytes,
						e.interval_wire_bytes);
				if (out_ch.interval_expired != e.interval_expired)
					report_mismatch("interval_expired", out_ch.interval_expired,
						e.interval_expired);
				if (out_ch.packet_rate != e.packet_rate)
					report_mismatch("packet_rate", out_ch.packet_rate, e.packet_rate);
				if (out_ch.captured_mbps != e.captured_mbps)
					report_mismatch("captured_mbps", out_ch.captured_mbps, e.captured_mbps);
				if (out_ch.wire_mbps != e.wire_mbps)
					report_mismatch("wire_mbps", out_ch.wire_mbps, e.wire_mbps);
				if (out_ch.usage_percent != e.usage_percent)
					report_mismatch("usage_percent", out_ch.usage_percent, e.usage_percent);
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (start_hold && !hold_done) begin
			hold_done <= 1;
			hold_left <= 400;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		int s;
		if (arst_n) begin
			s = stall_left;
			if (got) s = idle_mode ? $urandom_range(0, 19) : 0;
			else if (s > 0) s = s - 1;
			stall_left <= s;
			out_ch.ready <= (hold_left == 0) && (s == 0);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
		wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_ch.valid);
		repeat (4) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_INTERVAL: m_interval = v;
			CFG_CAPACITY: m_capacity = v[24:0];
			CFG_START_S: begin
				m_base_s = v;
				g_s = {32'd0, v};
			end
			default: m_base_ns = v[29:0];
		endcase
	endtask

	task automatic set_regs(input logic [31:0] iv, input logic [24:0] cap,
			input logic [31:0] ss, input logic [29:0] sns);
		write_reg(CFG_INTERVAL, iv);
		write_reg(CFG_CAPACITY, {7'd0, cap});
		write_reg(CFG_START_S, ss);
		write_reg(CFG_START_NS, {2'd0, sns});
	endtask

	function automatic stim_t noise_item(input logic [1:0] cmd);
		stim_t it;
		it.cmd = cmd;
		it.snap_len = 16'($urandom);
		it.frame_len = 16'($urandom);
		it.expired_flows = 16'($urandom);
		it.now_seconds = $urandom;
		it.now_nanoseconds = 30'($urandom);
		it.active_flows = 24'($urandom);
		it.drain = 0;
		return it;
	endfunction

	task automatic push_observe(input logic [31:0] s, input logic [29:0] ns,
			input logic [23:0] act);
		stim_t it;
		it = noise_item(CMD_OBSERVE);
		it.now_seconds = s;
		it.now_nanoseconds = ns;
		it.active_flows = act;
		pending_q.push_back(it);
	endtask

	task automatic push_random(input int n);
		stim_t it;
		int r;
		int k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				it = noise_item(CMD_PACKET);
				k = $urandom_range(0, 9);
				if (k == 0) it.snap_len = 16'hFFFF;
				if (k == 1) it.frame_len = 16'd0;
				pending_q.push_back(it);
			end else if (r < 65) begin
				pending_q.push_back(noise_item(CMD_EXPIRE));
			end else if (r < 96) begin
				k = $urandom_range(0, 9);
				if (k < 8) begin
					g_s = g_s + {32'd0, $urandom_range(0, 3)};
					if ($urandom_range(0, 3) == 0) g_s = g_s + {32'd0, m_interval};
					push_observe(g_s[31:0], 30'($urandom_range(0, 999999999)),
						(m_capacity > 25'hFFFFFF) ? 24'($urandom) :
						24'($urandom_range(0, m_capacity)));
				end else if (k == 8) begin
					push_observe(g_s[31:0] - $urandom_range(0, 2),
						30'($urandom_range(0, 999999999)),
						24'($urandom_range(0, m_capacity)));
				end else begin
					push_observe(g_s[31:0], 30'($urandom), 24'($urandom));
				end
			end else begin
				pending_q.push_back(noise_item(OP_BAD));
			end
		end
	endtask

	initial begin
		stim_t it;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_INTERVAL;
		cfg_data = 0;
		in_ch.valid = 0;
		in_ch.cmd = CMD_PACKET;
		in_ch.snap_len = 0;
		in_ch.frame_len = 0;
		in_ch.expired_flows = 0;
		in_ch.now_seconds = 0;
		in_ch.now_nanoseconds = 0;
		in_ch.active_flows = 0;
		out_ch.ready = 0;
		m_interval = INTERVAL_RESET;
		m_capacity = CAPACITY_RESET;
		m_base_s = 0;
		m_base_ns = 0;
		for (int i = 0; i < 4; i++) begin
			m_tot[i] = 0;
			m_base_tot[i] = 0;
		end
		g_s = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;

		// directed, reset register values
		it = noise_item(CMD_PACKET);
		it.snap_len = 16'hFFFF;
		it.frame_len = 16'hFFFF;
		pending_q.push_back(it);
		it.snap_len = 0;
		it.frame_len = 0;
		pending_q.push_back(it);
		it = noise_item(CMD_EXPIRE);
		it.expired_flows = 16'hFFFF;
		pending_q.push_back(it);
		it.expired_flows = 0;
		pending_q.push_back(it);
		pending_q.push_back(noise_item(OP_BAD));
		push_observe(0, 500, 100);
		push_observe(0, 30'd1000000000, 0);
		push_observe(0, 30'h3FFFFFFF, 0);
		push_observe(1, 0, 24'd65537);
		push_observe(1, 0, 24'd65536);
		push_observe(1, 999999999, 0);
		push_observe(1, 5, 0);
		push_observe(3, 4, 24'd32768);
		push_observe(32'hFFFFFFFF, 999999999, 1);
		push_random(200);

		set_regs(1, 1, $urandom, 999999999);
		push_observe(g_s[31:0] + 1, 0, 1);
		push_observe(g_s[31:0] + 1, 0, 2);
		push_random(200);

		set_regs(0, 25'd16777216, 32'hFFFFFFFF, 0);
		push_observe(32'hFFFFFFFF, 5, 24'hFFFFFF);
		push_random(20);
		write_reg(CFG_CAPACITY, 0);
		push_random(20);
		set_regs(2, 25'd16777216, 0, 30'h3FFFFFFF);
		push_random(20);
		write_reg(CFG_START_NS, 0);
		push_observe(2, 0, 24'hFFFFFF);
		push_random(200);

		set_regs(32'hFFFFFFFF, 25'($urandom_range(1, 25'd16777216)), 0, 0);
		push_observe(32'hFFFFFFFF, 999999999, 0);
		push_random(150);

		set_regs($urandom_range(1, 5), 25'($urandom_range(1, 5000)), $urandom,
			30'($urandom_range(0, 999999999)));
		// fill the queue while results are held off
		idle_mode = 0;
		it = noise_item(CMD_PACKET);
		it.drain = 1;
		pending_q.push_back(it);
		for (int i = 0; i < 60; i++)
			pending_q.push_back(noise_item(CMD_PACKET));
		wait (pending_q.size() < 60);
		start_hold = 1;
		push_random(150);
		wait (pending_q.size() == 0);
		idle_mode = 1;
		it = noise_item(CMD_EXPIRE);
		it.drain = 1;
		pending_q.push_back(it);
		push_random(200);

		set_regs($urandom_range(1, 3), 25'($urandom_range(1, 25'd16777216)), $urandom, 0);
		push_random(150);

		wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
		repeat (600) @(negedge clk);
		$display("sent %0d transactions, checked %0d results, %0d of them reports",
			items_sent, results_seen, reports_seen);
		$display("covered register changes between phases, invalid and backwards time, long stalls");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
